[sv/b2da_pkg.sv]
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

    // Integer width handled by the converter (8 to 64)
    localparam int VALUE_WIDTH = 64;

    // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
    function automatic int dec_digits(input int w);
        logic [63:0] v;
        int          n;
        begin
            v = 64'd1 << (w - 1);
            n = 0;
            while (v != 64'd0)
            begin
                v = v / 64'd10;
                n = n + 1;
            end
            return n;
        end
    endfunction

    localparam int NUM_DIGITS = dec_digits(VALUE_WIDTH);
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ASCII codes, 6-bit
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    // Classified value: sign and unsigned magnitude
    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
    } item_t;

    // Front to queue write port
    typedef struct packed {
        logic  push;
        item_t item;
    } queue_wr_t;

    // Queue to back read port
    typedef struct packed {
        logic  not_empty;
        item_t item;
    } queue_rd_t;

endpackage

`default_nettype wire

[sv/b2da_front.sv]
// ----------------------------------------------------------------------------
// b2da_front
// Accepts a value, splits it into sign and unsigned magnitude, and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_front
    import b2da_pkg::*;
(
    input  wire logic        start,
    input  wire logic [63:0] value,
    input  wire logic        queue_full,
    output logic             busy,
    output queue_wr_t        wr
);

    logic [VALUE_WIDTH-1:0] v;

    // Only the low VALUE_WIDTH bits count; the top one is the sign
    assign v = value[VALUE_WIDTH-1:0];

    // Classify; the most negative value negates to 2^(W-1), fine unsigned
    always_comb
    begin
        wr.push     = start & ~queue_full;
        wr.item.neg = v[VALUE_WIDTH-1];
        wr.item.mag = v[VALUE_WIDTH-1] ? (~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;
    end

    assign busy = queue_full;

endmodule

`default_nettype wire

[sv/b2da_queue.sv]
// ----------------------------------------------------------------------------
// b2da_queue
// Short FIFO of classified values between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_queue
    import b2da_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire queue_wr_t wr,
    input  wire logic      pop,
    output logic           full,
    output queue_rd_t      rd
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    assign full         = (count_reg == CNT_FULL);
    assign rd.not_empty = (count_reg != '0);
    assign rd.item      = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr.push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.item;
        end
    end

endmodule

`default_nettype wire

[sv/b2da_back.sv]
// ----------------------------------------------------------------------------
// b2da_back
// Converts a magnitude to BCD one bit a cycle (shift and add 3), then emits
// the sign and the significant digits one character a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_back
    import b2da_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire queue_rd_t rd,
    output logic           pop,
    output logic           char_valid,
    output logic [5:0]     char_code,
    output logic           last_char
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [CNT_W-1:0] BITS_ALL  = CNT_W'(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] BITS_ONE  = CNT_W'(1);
    localparam logic [DIG_W-1:0] DIG_TOP   = DIG_W'(NUM_DIGITS - 1);

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [VALUE_WIDTH-1:0] shift_reg;
    logic [VALUE_WIDTH-1:0] shift_next;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [CNT_W-1:0]       bit_cnt_reg;
    logic [CNT_W-1:0]       bit_cnt_next;
    logic [DIG_W-1:0]       idx_reg;
    logic [DIG_W-1:0]       idx_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic                   valid_next;
    logic [5:0]             code_reg;
    logic [5:0]             code_next;
    logic                   last_reg;
    logic                   last_next;
    logic [3:0]             top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        shift_next   = shift_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        idx_next     = idx_reg;
        neg_next     = neg_reg;
        valid_next   = 1'b0;
        code_next    = code_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (rd.not_empty)
                begin
                    pop          = 1'b1;
                    shift_next   = rd.item.mag;
                    neg_next     = rd.item.neg;
                    bcd_next     = '0;
                    bit_cnt_next = BITS_ALL;
                    idx_next     = DIG_TOP;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], shift_reg[VALUE_WIDTH-1]};
                shift_next   = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BITS_ONE)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, keep at least one digit
                if (top_digit == 4'd0 && idx_reg != '0)
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    if (neg_reg)
                    begin
                        valid_next = 1'b1;
                        code_next  = CHAR_MINUS;
                        last_next  = 1'b0;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                code_next  = CHAR_ZERO + {2'b00, top_digit};
                last_next  = (idx_reg == '0);
                bcd_next   = {bcd_reg[BCD_W-5:0], 4'd0};
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            char_valid <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            char_valid <= valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        idx_reg     <= idx_next;
        neg_reg     <= neg_next;
        code_reg    <= code_next;
        last_reg    <= last_next;
    end

    assign char_code = code_reg;
    assign last_char = last_reg & char_valid;

endmodule

`default_nettype wire

[sv/binary_to_decimal_ascii_top.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Signed integer to decimal ASCII text, one character per strobe.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each value comes
// out as its decimal text: a minus sign for a negative value, then the
// digits of the magnitude, most significant first, without leading zeros;
// zero gives a single '0'. Each character is on char_code for one cycle with
// char_valid high, and last_char marks the final one; the receiver cannot
// stall it. In the back end each value is fetched from the queue, put through
// the bit-serial BCD conversion, stripped of leading zeros and sent as
// characters. A two-entry queue lets up to two values wait while one is
// converted; busy is high while it is full.
`default_nettype none

module binary_to_decimal_ascii_top
    import b2da_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] value,
    output logic             char_valid,
    output logic [5:0]       char_code,
    output logic             last_char
);

    queue_wr_t wr;
    queue_rd_t rd;
    logic      queue_full;
    logic      pop;

    // Front: classify and enqueue
    b2da_front u_front (
        .start      (start),
        .value      (value),
        .queue_full (queue_full),
        .busy       (busy),
        .wr         (wr)
    );

    // Queue between front and back
    b2da_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .pop   (pop),
        .full  (queue_full),
        .rd    (rd)
    );

    // Back: convert and emit
    b2da_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd         (rd),
        .pop        (pop),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last_char  (last_char)
    );

    // Every character is a minus sign or a digit
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (char_code == CHAR_MINUS ||
                        (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 6'd9)))
        else $error("invalid character code");

    // A minus sign never ends the text
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_code == CHAR_MINUS) |-> !last_char)
        else $error("minus sign marked last");

    // A digit follows the minus sign in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_code == CHAR_MINUS) |=> (char_valid && char_code != CHAR_MINUS))
        else $error("no digit after minus sign");

    // The last mark only comes with a character
    assert property (@(posedge clk) disable iff (!rst_n)
        last_char |-> char_valid)
        else $error("last mark without character");

endmodule

`default_nettype wire
